FILE: sv/imconv_pkg.sv
// ----------------------------------------------------------------------------
// imconv_pkg
// Shared types, constants and helpers of the 3x3 clamped convolution block.
// ----------------------------------------------------------------------------
package imconv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_ROWS  = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = COL_W + 1;
    localparam int HGT_W      = ROW_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int VALUE_W    = 28;
    localparam int ACC_W      = 20;
    localparam int PROD_W     = 38;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HGT   = 3'd6;

    // effective (range-limited) configuration
    typedef struct packed {
        logic [2:0][23:0]   coef_row;
        logic [16:0]        inv;
        logic signed [15:0] bias;
        logic [WID_W-1:0]   width;
        logic [HGT_W-1:0]   height;
    } cfg_t;

    // one queued job for the back end
    typedef struct packed {
        logic                  emit;
        logic                  write;
        logic [1:0]            wr_slot;
        logic [COL_W-1:0]      wr_col;
        logic [7:0]            pixel;
        logic [2:0][1:0]       rd_slot;
        logic [2:0][COL_W-1:0] rd_col;
        logic [2:0][2:0]       fwd;
        logic [COL_W-1:0]      out_x;
        logic [ROW_W-1:0]      out_y;
        logic                  last;
    } job_t;

    // row mod 3: base-4 digits sum keeps the residue
    function automatic logic [1:0] mod3(input logic [ROW_W-1:0] v);
        logic [4:0] s;
        logic [2:0] s2;
        logic [2:0] s3;
        s = '0;
        for (int i = 0; i < ROW_W / 2; i++)
        begin
            s = s + {3'd0, v[2*i +: 2]};
        end
        s2 = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'd0, s[4]};
        s3 = {1'b0, s2[1:0]} + {2'd0, s2[2]};
        if (s3 >= 3'd3)
        begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

endpackage

FILE: sv/imconv_stream_if.sv
// ----------------------------------------------------------------------------
// imconv_stream_if
// Valid/ready channels: pixel input and filtered result output.
// ----------------------------------------------------------------------------
interface imconv_pix_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] pixel;
    modport source (output valid, action, pixel, input ready);
    modport sink   (input valid, action, pixel, output ready);
endinterface

interface imconv_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [imconv_pkg::VALUE_W-1:0]  value;
    logic [imconv_pkg::COL_W-1:0]           out_x;
    logic [imconv_pkg::ROW_W-1:0]           out_y;
    logic                                   frame_last;
    modport source (output valid, value, out_x, out_y, frame_last, input ready);
    modport sink   (input valid, value, out_x, out_y, frame_last, output ready);
endinterface

FILE: sv/image_convolution_3x3_clamped.sv
// ----------------------------------------------------------------------------
// image_convolution_3x3_clamped
// 3x3 convolution with replicate borders, Q1.16 scaling and integer bias.
// ----------------------------------------------------------------------------
// Front end: a drain beat stays in F_IDLE; a pixel beat goes F_IDLE, F_MUL
// (index multiply), F_DEC. Back end: an output goes B_IDLE, B_RD (three column
// reads of the 3-row line store, accumulate), B_TAIL, B_MUL (scale multiply),
// B_FIN (result register); a pixel without output goes B_IDLE, B_WR.
// Reset clears counters, queue, result valid and config to defaults; the line
// store is not cleared.
// ----------------------------------------------------------------------------
module image_convolution_3x3_clamped (
    input  logic                                  clk,
    input  logic                                  rst_n,
    imconv_pix_if.sink                            pix_in,
    imconv_res_if.source                          res_out,
    input  logic                                  cfg_we,
    input  logic [imconv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imconv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [2:0][23:0] coef_reg;
    logic [16:0]      inv_reg;
    logic [15:0]      bias_reg;
    logic [10:0]      width_reg;
    logic [12:0]      height_reg;

    imconv_pkg::cfg_t cfg;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    imconv_pkg::job_t q_data;
    imconv_pkg::job_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= 24'd65536;
            coef_reg[1] <= 24'd256;
            coef_reg[2] <= 24'd0;
            inv_reg     <= 17'd65536;
            bias_reg    <= 16'd0;
            width_reg   <= 11'd1024;
            height_reg  <= 13'd768;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imconv_pkg::CFG_COEF_ROW_0:  coef_reg[0] <= cfg_wdata;
                imconv_pkg::CFG_COEF_ROW_1:  coef_reg[1] <= cfg_wdata;
                imconv_pkg::CFG_COEF_ROW_2:  coef_reg[2] <= cfg_wdata;
                imconv_pkg::CFG_INV_DIVISOR: inv_reg     <= cfg_wdata[16:0];
                imconv_pkg::CFG_BIAS:        bias_reg    <= cfg_wdata[15:0];
                imconv_pkg::CFG_IMAGE_WIDTH: width_reg   <= cfg_wdata[10:0];
                imconv_pkg::CFG_IMAGE_HGT:   height_reg  <= cfg_wdata[12:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.coef_row = coef_reg;
        cfg.inv      = (inv_reg > 17'd65536) ? 17'd65536 : inv_reg;
        cfg.bias     = $signed(bias_reg);
        if (width_reg == '0)
        begin
            cfg.width = imconv_pkg::WID_W'(1);
        end
        else if (width_reg > 11'(imconv_pkg::MAX_WIDTH))
        begin
            cfg.width = imconv_pkg::WID_W'(imconv_pkg::MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end
        if (height_reg == '0)
        begin
            cfg.height = imconv_pkg::HGT_W'(1);
        end
        else if (height_reg > 13'(imconv_pkg::MAX_HEIGHT))
        begin
            cfg.height = imconv_pkg::HGT_W'(imconv_pkg::MAX_HEIGHT);
        end
        else
        begin
            cfg.height = height_reg;
        end
    end

    imconv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pix_in (pix_in),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    imconv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    imconv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .res_out (res_out)
    );

endmodule

FILE: sv/imconv_ram.sv
// ----------------------------------------------------------------------------
// imconv_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module imconv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/imconv_queue.sv
// ----------------------------------------------------------------------------
// imconv_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module imconv_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  imconv_pkg::job_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output imconv_pkg::job_t  head
);

    imconv_pkg::job_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: sv/imconv_front.sv
// ----------------------------------------------------------------------------
// imconv_front
// Accepts pixels and drains, tracks frame positions, decides on outputs and
// builds window addresses for the back end.
// ----------------------------------------------------------------------------
module imconv_front (
    input  logic              clk,
    input  logic              rst_n,
    input  imconv_pkg::cfg_t  cfg,
    imconv_pix_if.sink        pix_in,
    input  logic              q_full,
    output logic              q_push,
    output imconv_pkg::job_t  q_data
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_DEC} fstate_t;

    localparam int CW = imconv_pkg::COL_W;
    localparam int RW = imconv_pkg::ROW_W;
    localparam int WW = imconv_pkg::WID_W;
    localparam int HW = imconv_pkg::HGT_W;

    fstate_t       state_reg;
    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic          fid_reg;
    logic [CW-1:0] cx_reg;
    logic [RW-1:0] cy_reg;
    logic [7:0]    pix_reg;
    logic [23:0]   prod_reg;

    logic          accept;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    logic [CW-1:0] ox;
    logic [RW-1:0] oy;
    logic [2:0][CW-1:0] sx;
    logic [2:0][RW-1:0] sy;
    logic [WW-1:0] oc1;
    logic [CW-1:0] ncol;
    logic [HW-1:0] nrow;
    logic          last;
    logic [24:0]   target;
    logic [24:0]   lhs;
    logic          emit_ok;
    logic [CW-1:0] base_in_col;
    logic [RW-1:0] base_in_row;
    logic [WW-1:0] ic1;
    logic [HW-1:0] ir1;

    assign pix_in.ready = (state_reg == F_IDLE) && !q_full;
    assign accept       = pix_in.valid && pix_in.ready;

    always_comb
    begin
        wm1 = CW'(cfg.width - WW'(1));
        hm1 = RW'(cfg.height - HW'(1));
        ox  = ({1'b0, out_col_reg} >= cfg.width)  ? wm1 : out_col_reg;
        oy  = ({1'b0, out_row_reg} >= cfg.height) ? hm1 : out_row_reg;

        sx[0] = (ox == '0) ? '0 : ox - CW'(1);
        sx[1] = ox;
        sx[2] = (({1'b0, ox} + WW'(1)) >= cfg.width) ? wm1 : ox + CW'(1);
        sy[0] = (oy == '0) ? '0 : oy - RW'(1);
        sy[1] = oy;
        sy[2] = (({1'b0, oy} + HW'(1)) >= cfg.height) ? hm1 : oy + RW'(1);

        // next output position after this one leaves
        oc1 = {1'b0, out_col_reg} + WW'(1);
        if (oc1 >= cfg.width)
        begin
            ncol = '0;
            nrow = {1'b0, out_row_reg} + HW'(1);
        end
        else
        begin
            ncol = oc1[CW-1:0];
            nrow = {1'b0, out_row_reg};
        end
        last = (nrow >= cfg.height);
        if (last)
        begin
            ncol = '0;
            nrow = '0;
        end

        // output n leaves once input n + width + 1 is here
        target  = 25'({12'd0, out_row_reg} * {13'd0, cfg.width})
                + 25'(out_col_reg) + 25'(cfg.width) + 25'd1;
        lhs     = 25'(prod_reg) + 25'(cx_reg);
        emit_ok = ({1'b0, out_row_reg} < cfg.height) && (lhs >= target);

        base_in_col = fid_reg ? '0 : in_col_reg;
        base_in_row = fid_reg ? '0 : in_row_reg;
        ic1 = {1'b0, cx_reg} + WW'(1);
        ir1 = {1'b0, cy_reg} + HW'(1);

        q_push = (state_reg == F_DEC)
              || ((state_reg == F_IDLE) && accept && pix_in.action && fid_reg);

        q_data.emit    = (state_reg == F_DEC) ? emit_ok : 1'b1;
        q_data.write   = (state_reg == F_DEC);
        q_data.wr_slot = imconv_pkg::mod3(cy_reg);
        q_data.wr_col  = cx_reg;
        q_data.pixel   = pix_reg;
        for (int ky = 0; ky < 3; ky++)
        begin
            q_data.rd_slot[ky] = imconv_pkg::mod3(sy[ky]);
            q_data.rd_col[ky]  = sx[ky];
            for (int kx = 0; kx < 3; kx++)
            begin
                q_data.fwd[ky][kx] = (state_reg == F_DEC)
                                  && (sx[kx] == cx_reg) && (sy[ky] == cy_reg);
            end
        end
        q_data.out_x = out_col_reg;
        q_data.out_y = out_row_reg;
        q_data.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            fid_reg     <= 1'b0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            pix_reg     <= '0;
            prod_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        if (pix_in.action)
                        begin
                            if (fid_reg)
                            begin
                                out_col_reg <= ncol;
                                out_row_reg <= nrow[RW-1:0];
                                if (last)
                                begin
                                    fid_reg <= 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            // a pixel after the frame's end starts a new frame
                            if (fid_reg)
                            begin
                                out_col_reg <= '0;
                                out_row_reg <= '0;
                            end
                            fid_reg <= 1'b0;
                            cx_reg  <= ({1'b0, base_in_col} >= cfg.width)
                                     ? wm1 : base_in_col;
                            cy_reg  <= ({1'b0, base_in_row} >= cfg.height)
                                     ? hm1 : base_in_row;
                            pix_reg   <= pix_in.pixel;
                            state_reg <= F_MUL;
                        end
                    end
                end
                F_MUL:
                begin
                    prod_reg  <= 24'({12'd0, cy_reg} * {13'd0, cfg.width});
                    state_reg <= F_DEC;
                end
                F_DEC:
                begin
                    if (emit_ok)
                    begin
                        out_col_reg <= ncol;
                        out_row_reg <= nrow[RW-1:0];
                        if (last)
                        begin
                            fid_reg <= 1'b0;
                        end
                    end
                    if (ic1 >= cfg.width)
                    begin
                        in_col_reg <= '0;
                        if (ir1 >= cfg.height)
                        begin
                            in_row_reg <= '0;
                            fid_reg    <= 1'b1;
                        end
                        else
                        begin
                            in_row_reg <= ir1[RW-1:0];
                        end
                    end
                    else
                    begin
                        in_col_reg <= ic1[CW-1:0];
                        in_row_reg <= cy_reg;
                    end
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/imconv_back.sv
// ----------------------------------------------------------------------------
// imconv_back
// Reads the 3x3 window from the line store, accumulates, scales, adds bias,
// drives the result register and writes the new pixel.
// ----------------------------------------------------------------------------
module imconv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  imconv_pkg::cfg_t  cfg,
    input  logic              q_valid,
    input  imconv_pkg::job_t  q_head,
    output logic              q_pop,
    imconv_res_if.source      res_out
);

    typedef enum logic [2:0] {B_IDLE, B_RD, B_TAIL, B_MUL, B_FIN, B_WR} bstate_t;

    localparam int CW = imconv_pkg::COL_W;
    localparam int AW = imconv_pkg::ACC_W;
    localparam int PW = imconv_pkg::PROD_W;
    localparam int VW = imconv_pkg::VALUE_W;

    bstate_t           state_reg;
    imconv_pkg::job_t  cur_reg;
    logic [1:0]        k_reg;
    logic [1:0]        rd_k_reg;
    logic              rd_valid_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic              out_valid_reg;
    logic signed [VW-1:0] value_reg;
    logic [CW-1:0]     out_x_reg;
    logic [imconv_pkg::ROW_W-1:0] out_y_reg;
    logic              last_reg;

    logic [2:0][7:0]   rdata;
    logic [2:0]        ram_we;
    logic [CW-1:0]     raddr;
    logic signed [AW-1:0] col_sum;
    logic signed [PW-1:0] scaled;
    logic              fin_go;

    genvar gi;
    generate
        for (gi = 0; gi < imconv_pkg::LINE_ROWS; gi++)
        begin : g_line
            imconv_ram #(
                .WIDTH (8),
                .DEPTH (imconv_pkg::MAX_WIDTH)
            ) u_ram (
                .clk   (clk),
                .we    (ram_we[gi]),
                .waddr (cur_reg.wr_col),
                .wdata (cur_reg.pixel),
                .raddr (raddr),
                .rdata (rdata[gi])
            );
        end
    endgenerate

    assign fin_go = !out_valid_reg || res_out.ready;
    assign q_pop  = (state_reg == B_IDLE) && q_valid;
    assign raddr  = cur_reg.rd_col[k_reg];

    always_comb
    begin
        logic [7:0]         p;
        logic signed [7:0]  c;
        logic signed [16:0] term;
        col_sum = '0;
        for (int ky = 0; ky < 3; ky++)
        begin
            p    = cur_reg.fwd[ky][rd_k_reg] ? cur_reg.pixel : rdata[cur_reg.rd_slot[ky]];
            c    = $signed(cfg.coef_row[ky][8*rd_k_reg +: 8]);
            term = c * $signed({1'b0, p});
            col_sum = col_sum + AW'(term);
        end

        // arithmetic shift is floor division by 256
        scaled = (prod_reg >>> 8) + (PW'(cfg.bias) <<< 8);

        for (int s = 0; s < 3; s++)
        begin
            ram_we[s] = cur_reg.write && (cur_reg.wr_slot == 2'(s))
                     && ((state_reg == B_WR) || ((state_reg == B_FIN) && fin_go));
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.value      = value_reg;
    assign res_out.out_x      = out_x_reg;
    assign res_out.out_y      = out_y_reg;
    assign res_out.frame_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cur_reg       <= '0;
            k_reg         <= '0;
            rd_k_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == B_RD);
            rd_k_reg     <= k_reg;
            if (rd_valid_reg)
            begin
                acc_reg <= acc_reg + col_sum;
            end
            // in B_FIN a taken beat is replaced by the next one below
            if (out_valid_reg && res_out.ready && (state_reg != B_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_head;
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= q_head.emit ? B_RD : B_WR;
                    end
                end
                B_RD:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= B_TAIL;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
                B_TAIL:
                begin
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    prod_reg  <= PW'(acc_reg * $signed({1'b0, cfg.inv}));
                    state_reg <= B_FIN;
                end
                B_FIN:
                begin
                    if (fin_go)
                    begin
                        out_valid_reg <= 1'b1;
                        value_reg     <= scaled[VW-1:0];
                        out_x_reg     <= cur_reg.out_x;
                        out_y_reg     <= cur_reg.out_y;
                        last_reg      <= cur_reg.last;
                        state_reg     <= B_IDLE;
                    end
                end
                B_WR:
                begin
                    state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
